// ===== rtl/epx_pkg.sv =====
// Shared constants, types and helper functions of the EPX 2x upscaler.
package epx_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = COL_W + 1;
    localparam int HGT_W      = ROW_W + 1;
    localparam int THR_W      = PIX_W + 1;
    localparam int CFG_W      = HGT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = PIX_W + 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

    typedef struct packed {
        logic [PIX_W-1:0] top_left;
        logic [PIX_W-1:0] top_right;
        logic [PIX_W-1:0] bottom_left;
        logic [PIX_W-1:0] bottom_right;
        logic [ROW_W-1:0] src_row;
        logic [COL_W-1:0] src_col;
        logic             run_last;
        logic             frame_last;
    } t_blk;

    function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] v);
        if (v == '0) begin
            return WID_W'(1);
        end else if (v > WID_W'(MAX_WIDTH)) begin
            return WID_W'(MAX_WIDTH);
        end
        return v;
    endfunction

    function automatic logic [HGT_W-1:0] eff_height(input logic [HGT_W-1:0] v);
        if (v == '0) begin
            return HGT_W'(1);
        end else if (v > HGT_W'(MAX_HEIGHT)) begin
            return HGT_W'(MAX_HEIGHT);
        end
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] x,
                                                  input logic [PIX_W-1:0] y);
        return (x > y) ? (x - y) : (y - x);
    endfunction

    // sum / 3 for sums below 768: multiply by 683 / 2048
    function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] s);
        logic [SUM_W+11-1:0] m;
        m = {11'd0, s} * (SUM_W + 11)'(683);
        return m[11 +: PIX_W];
    endfunction

    function automatic logic [SUM_W-1:0] sum3(input logic [PIX_W-1:0] x,
                                              input logic [PIX_W-1:0] y,
                                              input logic [PIX_W-1:0] z);
        return {2'b00, x} + {2'b00, y} + {2'b00, z};
    endfunction

endpackage

// ===== rtl/epx_threshold_upscale_2x.sv =====
// Top level of the EPX-style 2x pixel upscaler with blend threshold.
//
// Usage:
// Source pixels of one 8-bit plane enter in raster order on the s_axis
// channel, one word per pixel. Each word out on m_axis is one 2x2 block of
// the doubled image with the source row and column it expands; tlast marks
// the final block caused by an input pixel, tuser the frame's last block.
// Output runs one source row behind: the first row gives no blocks, later
// rows give the block of the pixel above, and the last row also gives its
// own block, so that row yields two words per pixel.
// Each block is registered into the output queue as its pixel is accepted.
// Throughput: one pixel per cycle while m_axis_tready stays high; in the last row each
// pixel yields two words, so input is throttled by the single output word per cycle.
// Each pixel reads both line stores once (two ports on the previous row,
// one on the row before it) and writes one; the reads for the next pixel
// are issued while the current one is accepted.
// A three-word output queue decouples the sides: s_axis_tready stays high
// while the queue holds at most one word, so a stalled receiver throttles
// input once the queue holds two words.
// Reset (synchronous, active low) sets threshold 0, width 640, height 480,
// and starts a new frame; s_axis_tready is low during reset; line stores are
// not cleared.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
// while no word is in flight.
module epx_threshold_upscale_2x (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [epx_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] pixel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] top_left, [15:8] top_right, [23:16] bottom_left,
    // [31:24] bottom_right, [43:32] src_row, [54:44] src_col, [55] zero
    output logic [epx_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,  // run_last
    output logic                              m_axis_tuser,  // frame_last
    input  logic                              i_cfg_we,
    input  logic [epx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [epx_pkg::CFG_W-1:0]         i_cfg_data
);
    import epx_pkg::*;

    localparam int QDEPTH = 3;

    // configuration
    logic [THR_W-1:0] r_thresh;
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;

    // frame position
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_sel, n_sel;
    logic [PIX_W-1:0] r_left;

    // output queue
    t_blk       r_q [QDEPTH];
    t_blk       n_q [QDEPTH];
    logic [1:0] r_cnt, n_cnt;

    logic             s_acc, m_pop;
    logic [PIX_W-1:0] p_in;
    logic [PIX_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [PIX_W-1:0] prev_cur, prev_nxt, older_cur;
    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic             last_col, last_row, has_above, interior;
    t_blk             blk_a, blk_b, res0, res1;
    logic [1:0]       n_res;
    logic [COL_W-1:0] raddr1;

    assign p_in  = s_axis_tdata[PIX_W-1:0];
    assign s_acc = s_axis_tvalid & s_axis_tready;
    assign m_pop = m_axis_tvalid & m_axis_tready;

    assign s_axis_tready = i_rst_n && (r_cnt <= 2'd1);
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {1'b0, r_q[0].src_col, r_q[0].src_row, r_q[0].bottom_right,
                            r_q[0].bottom_left, r_q[0].top_right, r_q[0].top_left};
    assign m_axis_tlast  = r_q[0].run_last;
    assign m_axis_tuser  = r_q[0].frame_last;

    // line stores: both read at the next pixel's column and the one after
    assign raddr1 = n_col + COL_W'(1);

    epx_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
        .i_clk    (i_clk),
        .i_we     (s_acc & r_sel),
        .i_waddr  (r_col),
        .i_wdata  (p_in),
        .i_raddr0 (n_col),
        .i_raddr1 (raddr1),
        .o_rdata0 (a_rd0),
        .o_rdata1 (a_rd1)
    );

    epx_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
        .i_clk    (i_clk),
        .i_we     (s_acc & ~r_sel),
        .i_waddr  (r_col),
        .i_wdata  (p_in),
        .i_raddr0 (n_col),
        .i_raddr1 (raddr1),
        .o_rdata0 (b_rd0),
        .o_rdata1 (b_rd1)
    );

    assign prev_cur  = r_sel ? b_rd0 : a_rd0;
    assign prev_nxt  = r_sel ? b_rd1 : a_rd1;
    assign older_cur = r_sel ? a_rd0 : b_rd0;

    assign w_eff     = eff_width(r_width);
    assign h_eff     = eff_height(r_height);
    assign last_col  = ({1'b0, r_col} + WID_W'(1)) >= w_eff;
    assign last_row  = ({1'b0, r_row} + HGT_W'(1)) >= h_eff;
    assign has_above = (r_row != '0);
    assign interior  = (r_row >= ROW_W'(2)) && (r_col != '0) && !last_col
                       && ({1'b0, r_row} < h_eff);

    // block of the pixel one row up
    always_comb begin
        logic [PIX_W-1:0] a, b, c, d, p;
        logic             bl_tl, bl_tr, bl_bl, bl_br;
        logic [2:0]       cnt;
        a = older_cur;
        b = prev_nxt;
        c = r_left;
        d = p_in;
        p = prev_cur;
        bl_tl = {1'b0, abs_diff(c, a)} < r_thresh;
        bl_tr = {1'b0, abs_diff(b, a)} < r_thresh;
        bl_bl = {1'b0, abs_diff(d, c)} < r_thresh;
        bl_br = {1'b0, abs_diff(b, d)} < r_thresh;
        cnt   = 3'(bl_tl) + 3'(bl_tr) + 3'(bl_bl) + 3'(bl_br);
        blk_a.top_left     = p;
        blk_a.top_right    = p;
        blk_a.bottom_left  = p;
        blk_a.bottom_right = p;
        if (interior && cnt < 3'd3) begin
            if (bl_tl) begin
                blk_a.top_left = div3(sum3(a, c, p));
            end
            if (bl_tr) begin
                blk_a.top_right = div3(sum3(a, b, p));
            end
            if (bl_bl) begin
                blk_a.bottom_left = div3(sum3(d, c, p));
            end
            if (bl_br) begin
                blk_a.bottom_right = div3(sum3(b, d, p));
            end
        end
        blk_a.src_row    = r_row - ROW_W'(1);
        blk_a.src_col    = r_col;
        blk_a.run_last   = ~last_row;
        blk_a.frame_last = 1'b0;
    end

    // own block of a last-row pixel
    always_comb begin
        blk_b.top_left     = p_in;
        blk_b.top_right    = p_in;
        blk_b.bottom_left  = p_in;
        blk_b.bottom_right = p_in;
        blk_b.src_row      = r_row;
        blk_b.src_col      = r_col;
        blk_b.run_last     = 1'b1;
        blk_b.frame_last   = last_col;
    end

    assign res0  = has_above ? blk_a : blk_b;
    assign res1  = blk_b;
    assign n_res = 2'(has_above) + 2'(last_row);

    // output queue: shift out at the head, append behind the last word
    always_comb begin
        logic [1:0] kept;
        kept = r_cnt - 2'(m_pop);
        for (int i = 0; i < QDEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (m_pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int i = 0; i < QDEPTH; i++) begin
            if (s_acc && n_res != 2'd0 && 2'(i) == kept) begin
                n_q[i] = res0;
            end
            if (s_acc && n_res == 2'd2 && 2'(i) == kept + 2'd1) begin
                n_q[i] = res1;
            end
        end
        n_cnt = kept + (s_acc ? n_res : 2'd0);
    end

    // next frame position
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_sel = r_sel;
        if (!i_rst_n) begin
            n_row = '0;
            n_col = '0;
            n_sel = 1'b0;
        end else if (s_acc) begin
            if (last_col) begin
                n_col = '0;
                n_sel = ~r_sel;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESH: r_thresh <= i_cfg_data[THR_W-1:0];
                    CFG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                    default: ;
                endcase
            end
            r_cnt <= n_cnt;
        end
        r_row <= n_row;
        r_col <= n_col;
        r_sel <= n_sel;
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_left <= prev_cur;
        end
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

// ===== rtl/epx_ram.sv =====
// Generic dual-read, single-write RAM with registered write-first reads.
module epx_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [DATA_W-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr0,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr1,
    output logic [DATA_W-1:0]          o_rdata0,
    output logic [DATA_W-1:0]          o_rdata1
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata0;
    logic [DATA_W-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= (i_we && i_raddr0 == i_waddr) ? i_wdata : r_mem[i_raddr0];
        r_rdata1 <= (i_we && i_raddr1 == i_waddr) ? i_wdata : r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ===== tb/epx_threshold_upscale_2x_tb.sv =====
// Self-checking testbench for the EPX 2x upscaler: predicted blocks vs. the m_axis stream.
`timescale 1ns / 1ps

module epx_threshold_upscale_2x_tb;

    import epx_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    class block_scoreboard;
        int unsigned thresh;
        int unsigned width_reg;
        int unsigned height_reg;
        logic [7:0]  line_mem [2][MAX_WIDTH];
        int unsigned prev_sel;
        int unsigned row_cnt;
        int unsigned col_cnt;
        int unsigned pixels_seen;
        int unsigned mismatches;
        t_blk        pending_blocks [$];

        function new();
            thresh = 0;
            width_reg = 640;
            height_reg = 480;
            foreach (line_mem[i, j]) line_mem[i][j] = '0;
            prev_sel = 0;
            row_cnt = 0;
            col_cnt = 0;
            pixels_seen = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_THRESH: thresh = data[8:0];
                CFG_WIDTH: width_reg = data[11:0];
                CFG_HEIGHT: height_reg = data[12:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned cap);
            if (v == 0) return 1;
            return (v > cap) ? cap : v;
        endfunction

        function int unsigned cur_width();
            return clamp_dim(width_reg, MAX_WIDTH);
        endfunction

        function bit at_frame_start();
            return row_cnt == 0 && col_cnt == 0;
        endfunction

        function int unsigned spread(int unsigned u, int unsigned v);
            return (u > v) ? u - v : v - u;
        endfunction

        // Works out the blocks caused by one accepted pixel and advances the position.
        function void note_pixel(logic [7:0] pin);
            int unsigned w, h, r, x, pv, od;
            int unsigned p, a, b, c, d, blends;
            bit last_col, last_row;
            t_blk blk;
            w = cur_width();
            h = clamp_dim(height_reg, MAX_HEIGHT);
            r = row_cnt;
            x = col_cnt % MAX_WIDTH;
            pv = prev_sel;
            od = 1 - prev_sel;
            last_col = (x + 1 >= w);
            last_row = (r + 1 >= h);
            pixels_seen++;
            if (r >= 1) begin
                p = line_mem[pv][x];
                blk.top_left = 8'(p);
                blk.top_right = 8'(p);
                blk.bottom_left = 8'(p);
                blk.bottom_right = 8'(p);
                if (r >= 2 && x > 0 && !last_col && r < h) begin
                    a = line_mem[od][x];
                    b = line_mem[pv][x + 1];
                    c = line_mem[pv][x - 1];
                    d = pin;
                    blends = 0;
                    if (spread(c, a) < thresh) begin
                        blk.top_left = 8'((a + c + p) / 3);
                        blends++;
                    end
                    if (spread(b, a) < thresh) begin
                        blk.top_right = 8'((a + b + p) / 3);
                        blends++;
                    end
                    if (spread(d, c) < thresh) begin
                        blk.bottom_left = 8'((d + c + p) / 3);
                        blends++;
                    end
                    if (spread(b, d) < thresh) begin
                        blk.bottom_right = 8'((b + d + p) / 3);
                        blends++;
                    end
                    if (blends >= 3) begin
                        blk.top_left = 8'(p);
                        blk.top_right = 8'(p);
                        blk.bottom_left = 8'(p);
                        blk.bottom_right = 8'(p);
                    end
                end
                blk.src_row = ROW_W'(r - 1);
                blk.src_col = COL_W'(x);
                blk.run_last = !last_row;
                blk.frame_last = 1'b0;
                pending_blocks.push_back(blk);
            end
            if (last_row) begin
                blk.top_left = pin;
                blk.top_right = pin;
                blk.bottom_left = pin;
                blk.bottom_right = pin;
                blk.src_row = ROW_W'(r);
                blk.src_col = COL_W'(x);
                blk.run_last = 1'b1;
                blk.frame_last = last_col;
                pending_blocks.push_back(blk);
            end
            line_mem[od][x] = pin;
            if (last_col) begin
                col_cnt = 0;
                prev_sel = od;
                row_cnt = last_row ? 0 : ((r + 1) & 12'hFFF);
            end else begin
                col_cnt = (x + 1) & 11'h7FF;
            end
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_block(t_blk got);
            t_blk want;
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected block, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_blocks.pop_front();
            compare_field("top_left", want.top_left, got.top_left);
            compare_field("top_right", want.top_right, got.top_right);
            compare_field("bottom_left", want.bottom_left, got.bottom_left);
            compare_field("bottom_right", want.bottom_right, got.bottom_right);
            compare_field("src_row", want.src_row, got.src_row);
            compare_field("src_col", want.src_col, got.src_col);
            compare_field("run_last", want.run_last, got.run_last);
            compare_field("frame_last", want.frame_last, got.frame_last);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    block_scoreboard blocks = new();
    int unsigned     tx_idle_pct;
    int unsigned     rx_idle_pct;
    int unsigned     cycle_count = 0;
    int              pix_level;

    epx_threshold_upscale_2x dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin : out_monitor
        t_blk got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.top_left = m_axis_tdata[7:0];
            got.top_right = m_axis_tdata[15:8];
            got.bottom_left = m_axis_tdata[23:16];
            got.bottom_right = m_axis_tdata[31:24];
            got.src_row = m_axis_tdata[43:32];
            got.src_col = m_axis_tdata[54:44];
            got.run_last = m_axis_tlast;
            got.frame_last = m_axis_tuser;
            blocks.check_block(got);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [7:0] pix);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        blocks.note_pixel(pix);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (blocks.pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(value);
        blocks.write_reg(idx, CFG_W'(value));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_row(input logic [7:0] row_pix [$]);
        foreach (row_pix[i]) send_pixel(row_pix[i]);
    endtask

    function automatic int unsigned pick_threshold();
        case ($urandom_range(7))
            0: return 0;
            1: return 256;
            2: return $urandom_range(257, 511);
            3: return 1;
            default: return $urandom_range(2, 60);
        endcase
    endfunction

    function automatic int unsigned pick_dim(int unsigned top);
        case ($urandom_range(7))
            0: return 0;
            1: return 1;
            2: return 2;
            default: return $urandom_range(3, top);
        endcase
    endfunction

    function automatic logic [7:0] next_pixel(int unsigned style);
        int v;
        case (style)
            0: return 8'($urandom_range(255));
            1: begin
                v = pix_level + int'($urandom_range(30)) - 15;
                return 8'((v < 0) ? 0 : (v > 255) ? 255 : v);
            end
            2: return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(3) * 80 + $urandom_range(6));
        endcase
    endfunction

    // One frame, optionally reshaped partway through (width never grows).
    task automatic run_frame();
        int unsigned style, split, sent, new_w;
        drain();
        write_cfg(CFG_THRESH, pick_threshold());
        if ($urandom_range(11) == 0) begin
            write_cfg(CFG_WIDTH, $urandom_range(MAX_WIDTH, 4095));
            write_cfg(CFG_HEIGHT, $urandom_range(MAX_HEIGHT, 8191));
            split = $urandom_range(4, 40);
        end else begin
            write_cfg(CFG_WIDTH, pick_dim(12));
            write_cfg(CFG_HEIGHT, pick_dim(8));
            split = ($urandom_range(4) == 0) ? $urandom_range(1, 60) : 0;
        end
        style = ($urandom_range(1) == 0) ? 1 : $urandom_range(3);
        pix_level = $urandom_range(255);
        sent = 0;
        do begin
            send_pixel(next_pixel(style));
            sent++;
            if (sent == split) begin
                drain();
                new_w = blocks.cur_width();
                new_w = $urandom_range(0, (new_w < 12) ? new_w : 12);
                write_cfg(CFG_WIDTH, new_w);
                write_cfg(CFG_HEIGHT, $urandom_range(0, 8));
                if ($urandom_range(1) == 0) write_cfg(CFG_THRESH, pick_threshold());
            end
        end while (!blocks.at_frame_start());
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned stop_at;
        stop_at = blocks.pixels_seen + n_items;
        while (blocks.pixels_seen < stop_at) run_frame();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_THRESH;
        i_cfg_data = '0;
        tx_idle_pct = 8;
        rx_idle_pct = 84;
        pix_level = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 at reset threshold: nothing may blend
        write_cfg(CFG_WIDTH, 3);
        write_cfg(CFG_HEIGHT, 3);
        send_row('{8'd0, 8'd255, 8'd0});
        send_row('{8'd255, 8'd128, 8'd255});
        send_row('{8'd0, 8'd255, 8'd1});
        drain();

        // 4x3: one interior pixel blends one quadrant, the other three (reverts)
        write_cfg(CFG_THRESH, 20);
        write_cfg(CFG_WIDTH, 4);
        send_row('{8'd7, 8'd0, 8'd100, 8'd255});
        send_row('{8'd10, 8'd135, 8'd220, 8'd115});
        send_row('{8'd200, 8'd255, 8'd125, 8'd3});
        drain();

        // zero geometry acts as a 1x1 frame
        write_cfg(CFG_THRESH, 256);
        write_cfg(CFG_WIDTH, 0);
        write_cfg(CFG_HEIGHT, 0);
        send_row('{8'd255, 8'd0});

        run_random(317);
        tx_idle_pct = 84;
        rx_idle_pct = 8;
        run_random(317);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(317);
        drain();

        if (blocks.mismatches == 0 && blocks.pending_blocks.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
